[rtl/sclp_pkg.sv]
`default_nettype none
package sclp_pkg;

	localparam int LINE_CAPACITY = 16;
	localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
	localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W         = $clog2(STORE_DEPTH);
	localparam int REPLY_MAX     = 8;
	localparam int REM_W         = $clog2(REPLY_MAX + 1);

	localparam int IN_W   = 24;
	localparam int OUT_W  = 16;
	localparam int KIND_W = 3;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP   = 8'd32;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_K     = 8'h4B;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_R     = 8'h52;
	localparam logic [7:0] CHAR_QUERY = 8'h3F;

	localparam logic [15:0] BEEP_MAX = 16'd200;

	typedef enum logic [KIND_W-1:0] {
		EV_START    = 3'd0,
		EV_KEY      = 3'd1,
		EV_FREQ     = 3'd2,
		EV_BEEP     = 3'd3,
		EV_CFG_DONE = 3'd4,
		EV_CLEAR    = 3'd5,
		EV_REPLY    = 3'd6
	} ev_kind_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_KEY,
		CMD_FREQ,
		CMD_BEEP,
		CMD_CFG,
		CMD_CLEAR,
		CMD_QUERY
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIGIT,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic store;
		logic clear_line;
		logic load_single;
		logic load_reply;
		logic num_start;
		logic num_read;
		logic num_step;
		logic load_num;
		logic pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_eol;
		logic fill_zero;
		logic fill_ge2;
		cmd_t cmd;
		logic num_more;
		logic digit_ok;
		logic acc_zero;
		logic rem_last;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/sclp_ctrl.sv]
`default_nettype none
module sclp_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  sclp_pkg::dp_stat_t    stat,
	output sclp_pkg::ctrl_cmd_t   cmd
);
	import sclp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!stat.is_eol) begin
						cmd.store = 1'b1;
					end else begin
						cmd.clear_line = 1'b1;
						if (!stat.fill_zero) begin
							unique case (stat.cmd)
								CMD_START, CMD_CFG, CMD_CLEAR: begin
									cmd.load_single = 1'b1;
									state_d = ST_EMIT;
								end
								CMD_KEY: begin
									if (stat.fill_ge2) begin
										cmd.load_single = 1'b1;
										state_d = ST_EMIT;
									end
								end
								CMD_FREQ, CMD_BEEP: begin
									cmd.num_start = 1'b1;
									state_d = stat.fill_ge2 ? ST_READ : ST_FINISH;
								end
								CMD_QUERY: begin
									cmd.load_reply = 1'b1;
									state_d = ST_EMIT;
								end
								default: state_d = ST_IDLE;
							endcase
						end
					end
				end
			end
			ST_READ: begin
				cmd.num_read = 1'b1;
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (stat.digit_ok) begin
					cmd.num_step = 1'b1;
					state_d = stat.num_more ? ST_READ : ST_FINISH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// frequency zero gives no event; beep rate always does
				if (stat.cmd == CMD_FREQ && stat.acc_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.load_num = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.pop = 1'b1;
					if (stat.rem_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/sclp_dp.sv]
`default_nettype none
module sclp_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [sclp_pkg::IN_W-1:0]    in_data,
	input  sclp_pkg::ctrl_cmd_t          cmd,
	output sclp_pkg::dp_stat_t           stat,
	output logic [sclp_pkg::OUT_W-1:0]   out_value,
	output logic [sclp_pkg::KIND_W-1:0]  out_kind,
	output logic                         out_last
);
	import sclp_pkg::*;

	logic [7:0] rx_byte;
	logic [6:0] wins_first, wins_second;

	assign rx_byte     = in_data[7:0];
	assign wins_first  = in_data[14:8];
	assign wins_second = in_data[21:15];

	logic [7:0]        store_mem [STORE_DEPTH];
	logic [7:0]        rdata_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] lim_q;
	logic [FILL_W-1:0] idx_q;
	logic [15:0]       acc_q;
	cmd_t              cmd_q;
	logic [7:0]        key_q;

	ev_kind_t          kind_q;
	logic [15:0]       val_q;
	logic [7:0]        reply_q [REPLY_MAX-1];
	logic [REM_W-1:0]  rem_q;

	// fold lower case and decode the command letter
	logic [7:0] folded;
	cmd_t       cmd_dec;

	always_comb begin
		folded = rx_byte;
		if (rx_byte >= CHAR_LO_A && rx_byte <= CHAR_LO_Z) begin
			folded = rx_byte - CASE_GAP;
		end
		unique case (folded)
			CHAR_S:     cmd_dec = CMD_START;
			CHAR_K:     cmd_dec = CMD_KEY;
			CHAR_F:     cmd_dec = CMD_FREQ;
			CHAR_B:     cmd_dec = CMD_BEEP;
			CHAR_C:     cmd_dec = CMD_CFG;
			CHAR_R:     cmd_dec = CMD_CLEAR;
			CHAR_QUERY: cmd_dec = CMD_QUERY;
			default:    cmd_dec = CMD_NONE;
		endcase
	end

	// split the counts into tens and ones: x/10 = (x*205)>>11 for x below 1024
	logic [14:0] prod1, prod2;
	logic [3:0]  tens1, tens2, ones1, ones2;
	logic [6:0]  tens1_x10, tens2_x10;

	always_comb begin
		prod1     = 15'(wins_first) * 15'd205;
		prod2     = 15'(wins_second) * 15'd205;
		tens1     = prod1[14:11];
		tens2     = prod2[14:11];
		tens1_x10 = 7'({tens1, 3'b000}) + 7'({tens1, 1'b0});
		tens2_x10 = 7'({tens2, 3'b000}) + 7'({tens2, 1'b0});
		ones1     = 4'(wins_first - tens1_x10);
		ones2     = 4'(wins_second - tens2_x10);
	end

	// assemble the status reply, first character in slot zero
	logic [7:0]       seq [REPLY_MAX];
	logic [REM_W-1:0] seq_len;

	always_comb begin
		for (int i = 0; i < REPLY_MAX; i++) begin
			seq[i] = CHAR_ZERO;
		end
		seq_len = '0;
		seq[seq_len[REM_W-2:0]] = CHAR_S;
		seq_len = seq_len + 1'b1;
		if (wins_first >= 7'd10) begin
			seq[seq_len[REM_W-2:0]] = CHAR_ZERO + 8'(tens1);
			seq_len = seq_len + 1'b1;
		end
		seq[seq_len[REM_W-2:0]] = CHAR_ZERO + 8'(ones1);
		seq_len = seq_len + 1'b1;
		seq[seq_len[REM_W-2:0]] = CHAR_COMMA;
		seq_len = seq_len + 1'b1;
		if (wins_second >= 7'd10) begin
			seq[seq_len[REM_W-2:0]] = CHAR_ZERO + 8'(tens2);
			seq_len = seq_len + 1'b1;
		end
		seq[seq_len[REM_W-2:0]] = CHAR_ZERO + 8'(ones2);
		seq_len = seq_len + 1'b1;
		seq[seq_len[REM_W-2:0]] = CHAR_CR;
		seq_len = seq_len + 1'b1;
		seq[seq_len[REM_W-2:0]] = CHAR_LF;
		seq_len = seq_len + 1'b1;
	end

	// line store: write on a stored character, read one entry during the number walk
	always_ff @(posedge clk) begin
		if (cmd.store && fill_q < FILL_W'(STORE_DEPTH)) begin
			store_mem[fill_q[IDX_W-1:0]] <= rx_byte;
		end
		if (cmd.num_read) begin
			rdata_q <= store_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.clear_line) begin
			fill_q <= '0;
		end else if (cmd.store && fill_q < FILL_W'(STORE_DEPTH)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && fill_q == '0) begin
			cmd_q <= cmd_dec;
		end
		if (cmd.store && fill_q == FILL_W'(1)) begin
			key_q <= rx_byte;
		end
	end

	// decimal number walk
	logic [15:0] acc_next;
	logic [3:0]  digit;

	assign digit    = 4'(rdata_q - CHAR_ZERO);
	assign acc_next = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + 16'(digit);

	always_ff @(posedge clk) begin
		if (cmd.num_start) begin
			acc_q <= '0;
			idx_q <= FILL_W'(1);
			lim_q <= fill_q;
		end else if (cmd.num_step) begin
			acc_q <= acc_next;
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register and reply queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.load_single || cmd.load_num) begin
			rem_q <= REM_W'(1);
		end else if (cmd.load_reply) begin
			rem_q <= seq_len;
		end else if (cmd.pop) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			val_q <= '0;
			unique case (cmd_q)
				CMD_START: kind_q <= EV_START;
				CMD_KEY: begin
					kind_q <= EV_KEY;
					val_q  <= {8'h00, key_q};
				end
				CMD_CFG:   kind_q <= EV_CFG_DONE;
				default:   kind_q <= EV_CLEAR;
			endcase
		end else if (cmd.load_num) begin
			if (cmd_q == CMD_FREQ) begin
				kind_q <= EV_FREQ;
				val_q  <= acc_q;
			end else begin
				kind_q <= EV_BEEP;
				val_q  <= (acc_q > BEEP_MAX) ? BEEP_MAX : acc_q;
			end
		end else if (cmd.load_reply) begin
			kind_q <= EV_REPLY;
			val_q  <= {8'h00, seq[0]};
			for (int i = 0; i < REPLY_MAX - 1; i++) begin
				reply_q[i] <= seq[i+1];
			end
		end else if (cmd.pop) begin
			// advance the reply queue by one character
			val_q <= {8'h00, reply_q[0]};
			for (int i = 0; i < REPLY_MAX - 2; i++) begin
				reply_q[i] <= reply_q[i+1];
			end
		end
	end

	assign out_value = val_q;
	assign out_kind  = kind_q;
	assign out_last  = (rem_q == REM_W'(1));

	always_comb begin
		stat.is_eol    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
		stat.fill_zero = (fill_q == '0);
		stat.fill_ge2  = (fill_q >= FILL_W'(2));
		stat.cmd       = cmd_q;
		stat.num_more  = ({1'b0, idx_q} + 1'b1) < {1'b0, lim_q};
		stat.digit_ok  = (rdata_q >= CHAR_ZERO) && (rdata_q <= CHAR_NINE);
		stat.acc_zero  = (acc_q == '0);
		stat.rem_last  = (rem_q == REM_W'(1));
	end

endmodule
`default_nettype wire

[rtl/serial_command_line_parser.sv]
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: rx_byte[7:0], wins_first[14:8], wins_second[21:15], zero pad
// m_axis    out        tdata: event_value; tuser: event_kind; tlast: last_of_run
//
// A stored character, an empty line, an unknown command or a lone K is handled in the idle state.
// A command line end then emits its events one per cycle while m_axis_tready is high;
// F and B first walk the line store, READ then DIGIT per character read (each digit and
// the first non-digit; registered read of the single-port store), then FINISH settles
// the value. Input is held off until the last event of the line is transferred.
// arst_n clears the controller and the fill count; the line store is not cleared.
`default_nettype none
module serial_command_line_parser (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [sclp_pkg::IN_W-1:0]    s_axis_tdata,  // rx_byte, wins_first, wins_second
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [sclp_pkg::OUT_W-1:0]   m_axis_tdata,  // event_value
	output logic [sclp_pkg::KIND_W-1:0]  m_axis_tuser,  // event_kind
	output logic                         m_axis_tlast
);
	import sclp_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	sclp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sclp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_value (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

[bench/serial_command_line_parser_tb.sv]
`default_nettype none
module serial_command_line_parser_tb;
	import sclp_pkg::*;

	localparam int RANDOM_ITEMS = 406;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DIRECTED_ROWS = 24;
	// command letters, S first, packed from the lowest byte up
	localparam logic [55:0] COMMAND_SET =
		{CHAR_QUERY, CHAR_R, CHAR_C, CHAR_B, CHAR_F, CHAR_K, CHAR_S};

	// how the expectation of a row is formed
	typedef enum logic [1:0] {
		ROW_PRED,
		ROW_NONE,
		ROW_ONE
	} row_tag_t;

	typedef struct packed {
		row_tag_t    tag;
		logic [7:0]  rx;
		logic [6:0]  wins_a;
		logic [6:0]  wins_b;
		ev_kind_t    kind;
		logic [15:0] value;
	} row_t;

	typedef struct {
		ev_kind_t    kind;
		logic [15:0] value;
		logic        last;
	} line_event_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic [KIND_W-1:0] m_axis_tuser;
	logic              m_axis_tlast;

	// travels alongside each transfer so the checker knows how to form its expectation
	row_tag_t    row_tag;
	ev_kind_t    row_kind;
	logic [15:0] row_value;

	logic [7:0]  held_chars [STORE_DEPTH];
	int          line_len;
	line_event_t fresh_events [$];
	line_event_t due_events [$];
	int          mismatches;
	int          cycle_count;
	bit          send_quiet;
	bit          take_quiet;

	row_t directed [DIRECTED_ROWS] = '{
		'{ROW_NONE, CHAR_CR,              7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_S,               7'd99,  7'd99, EV_START,    16'd0},
		'{ROW_ONE,  CHAR_CR,              7'd99,  7'd99, EV_START,    16'd0},
		'{ROW_NONE, CHAR_K + CASE_GAP,    7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, 8'hFF,                7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_ONE,  CHAR_LF,              7'd0,   7'd0,  EV_KEY,      16'h00FF},
		'{ROW_NONE, CHAR_F,               7'd1,   7'd2,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_CR,              7'd1,   7'd2,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_B + CASE_GAP,    7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_NINE,            7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_NINE,            7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_NINE,            7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_ONE,  CHAR_CR,              7'd0,   7'd0,  EV_BEEP,     BEEP_MAX},
		'{ROW_NONE, CHAR_C,               7'd10,  7'd9,  EV_START,    16'd0},
		'{ROW_ONE,  CHAR_CR,              7'd10,  7'd9,  EV_CFG_DONE, 16'd0},
		'{ROW_NONE, CHAR_R + CASE_GAP,    7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_ONE,  CHAR_LF,              7'd0,   7'd0,  EV_CLEAR,    16'd0},
		'{ROW_NONE, CHAR_QUERY,           7'd127, 7'd5,  EV_START,    16'd0},
		'{ROW_PRED, CHAR_CR,              7'd127, 7'd5,  EV_START,    16'd0},
		'{ROW_NONE, 8'h00,                7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_CR,              7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_F + CASE_GAP,    7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_NONE, CHAR_ZERO + 8'd1,     7'd0,   7'd0,  EV_START,    16'd0},
		'{ROW_ONE,  CHAR_CR,              7'd0,   7'd0,  EV_FREQ,     16'd1}
	};

	serial_command_line_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // rx_byte, wins_first, wins_second, zero pad
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // event_value
		.m_axis_tuser  (m_axis_tuser),  // event_kind
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_event(input ev_kind_t kind, input logic [15:0] value);
		line_event_t ev;
		ev.kind = kind;
		ev.value = value;
		ev.last = 1'b0;
		fresh_events.push_back(ev);
	endfunction

	function automatic void add_count(input logic [6:0] cnt);
		if (cnt >= 7'd10)
			add_event(EV_REPLY, 16'(CHAR_ZERO) + 16'(cnt / 7'd10));
		add_event(EV_REPLY, 16'(CHAR_ZERO) + 16'(cnt % 7'd10));
	endfunction

	// Works out the events that one received byte causes and keeps the line state.
	function automatic void parse_byte(input logic [7:0] rx, input logic [6:0] wins_a,
			input logic [6:0] wins_b);
		logic [7:0]  cmd;
		logic [15:0] num;
		int          i;
		fresh_events.delete();
		if (rx == CHAR_CR || rx == CHAR_LF) begin
			if (line_len > 0) begin
				cmd = held_chars[0];
				if (cmd >= CHAR_LO_A && cmd <= CHAR_LO_Z)
					cmd = cmd - CASE_GAP;
				// leading digits after the command, wrapping at 16 bits
				num = 16'd0;
				for (i = 1; i < line_len; i++) begin
					if (held_chars[i] < CHAR_ZERO || held_chars[i] > CHAR_NINE)
						break;
					num = 16'(num * 16'd10 + 16'(held_chars[i] - CHAR_ZERO));
				end
				case (cmd)
					CHAR_S: add_event(EV_START, 16'd0);
					CHAR_K: if (line_len >= 2) add_event(EV_KEY, {8'h00, held_chars[1]});
					CHAR_F: if (num != 16'd0) add_event(EV_FREQ, num);
					CHAR_B: add_event(EV_BEEP, (num > BEEP_MAX) ? BEEP_MAX : num);
					CHAR_C: add_event(EV_CFG_DONE, 16'd0);
					CHAR_R: add_event(EV_CLEAR, 16'd0);
					CHAR_QUERY: begin
						add_event(EV_REPLY, {8'h00, CHAR_S});
						add_count(wins_a);
						add_event(EV_REPLY, {8'h00, CHAR_COMMA});
						add_count(wins_b);
						add_event(EV_REPLY, {8'h00, CHAR_CR});
						add_event(EV_REPLY, {8'h00, CHAR_LF});
					end
					default: ;
				endcase
			end
			line_len = 0;
		end else if (line_len < STORE_DEPTH) begin
			held_chars[line_len] = rx;
			line_len++;
		end
		if (fresh_events.size() > 0)
			fresh_events[fresh_events.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		line_event_t got;
		line_event_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			parse_byte(s_axis_tdata[7:0], s_axis_tdata[14:8], s_axis_tdata[21:15]);
			if (row_tag != ROW_PRED) begin
				fresh_events.delete();
				if (row_tag == ROW_ONE)
					fresh_events.push_back('{row_kind, row_value, 1'b1});
			end
			foreach (fresh_events[i])
				due_events.push_back(fresh_events[i]);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = ev_kind_t'(m_axis_tuser);
			got.value = m_axis_tdata;
			got.last = m_axis_tlast;
			if (due_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d value %0h",
					got.kind, got.value));
			end else begin
				want = due_events.pop_front();
				if (got.kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, want %0d",
						got.kind, want.kind));
				if (got.value !== want.value)
					report_mismatch($sformatf("event_value %0h, want %0h",
						got.value, want.value));
				if (got.last !== want.last)
					report_mismatch($sformatf("last_of_run %b, want %b",
						got.last, want.last));
			end
		end
	end

	task automatic send_item(input logic [7:0] rx, input logic [6:0] wins_a,
			input logic [6:0] wins_b, input row_tag_t tag, input ev_kind_t kind,
			input logic [15:0] value);
		int gap;
		if ($urandom_range(0, 15) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, wins_b, wins_a, rx};
		row_tag <= tag;
		row_kind <= kind;
		row_value <= value;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
	endtask

	// sink side: hold off each event for a drawn number of cycles
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				take_quiet = !take_quiet;
			gap = take_quiet ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("serial_command_line_parser regression: fail");
		$finish;
	end

	initial begin
		logic [7:0] line_bytes [$];
		logic [7:0] letter;
		logic [7:0] cmd;
		logic [7:0] junk;
		logic [6:0] wins_a;
		logic [6:0] wins_b;
		int         pick;
		int         sent;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		row_tag = ROW_PRED;
		row_kind = EV_START;
		row_value = 16'd0;
		line_len = 0;
		mismatches = 0;
		cycle_count = 0;
		send_quiet = 1'b0;
		take_quiet = 1'b0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].rx, directed[i].wins_a, directed[i].wins_b,
				directed[i].tag, directed[i].kind, directed[i].value);

		// mostly well-formed command lines, some noise, empty and overlong lines
		while (sent < RANDOM_ITEMS) begin
			line_bytes.delete();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// empty line: terminator only
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 8))
					line_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				letter = COMMAND_SET[8 * $urandom_range(0, 6) +: 8];
				cmd = letter;
				if (letter != CHAR_QUERY && $urandom_range(0, 1) == 1)
					cmd = letter + CASE_GAP;
				line_bytes.push_back(cmd);
				if (pick < 24) begin
					// fill the store or run past it, so any later bytes are dropped
					repeat ($urandom_range(14, 22))
						line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
				end else begin
					if (letter == CHAR_F || letter == CHAR_B) begin
						repeat ($urandom_range(0, 6))
							line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
					end else if (letter == CHAR_K) begin
						repeat ($urandom_range(0, 2)) begin
							do junk = 8'($urandom_range(0, 255));
							while (junk == CHAR_CR || junk == CHAR_LF);
							line_bytes.push_back(junk);
						end
					end
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 3)) begin
							do junk = 8'($urandom_range(0, 255));
							while (junk == CHAR_CR || junk == CHAR_LF);
							line_bytes.push_back(junk);
						end
					end
				end
			end
			line_bytes.push_back(($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF);
			foreach (line_bytes[i]) begin
				wins_a = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 99));
				wins_b = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 99));
				send_item(line_bytes[i], wins_a, wins_b, ROW_PRED, EV_START, 16'd0);
				sent++;
			end
		end
		s_axis_tvalid <= 1'b0;

		// let the checker take the last transfer before looking at the queue
		@(posedge clk);
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", due_events.size()));
		if (mismatches == 0)
			$display("serial_command_line_parser regression: pass");
		else
			$display("serial_command_line_parser regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
